@@ rtl/paged_translation_fifo_lru_assert.svh @@
// Assertion macros for the block's RTL. Each expects clk and rst_n in scope.
`ifndef PAGED_TRANSLATION_FIFO_LRU_ASSERT_SVH
`define PAGED_TRANSLATION_FIFO_LRU_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define PTF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ptf assertion failed");

// A condition that implies another at the same edge.
`define PTF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptf assertion failed");

// A condition that implies another at the following edge.
`define PTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptf assertion failed");

`endif

@@ rtl/ptf_pkg.sv @@
package ptf_pkg;

    localparam int MAX_PAGES    = 64;
    localparam int MAX_RESIDENT = 16;
    localparam int BITMAP_BITS  = 4096;

    localparam int PAGE_AW  = $clog2(MAX_PAGES);
    localparam int RES_AW   = $clog2(MAX_RESIDENT);
    localparam int CNT_W    = RES_AW + 1;
    localparam int FRAME_W  = $clog2(BITMAP_BITS);
    localparam int ROW_W    = 64;
    localparam int ROW_LSB  = $clog2(ROW_W);
    localparam int ROWS     = BITMAP_BITS / ROW_W;
    localparam int ROW_AW   = FRAME_W - ROW_LSB;
    localparam int KB_SHIFT = 10;
    localparam int VA_W     = 26;
    localparam int VPN_W    = VA_W - KB_SHIFT;
    localparam int KB_W     = 11;
    localparam int REM_W    = 10;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_LOADED   = 3'd1,
        ST_REPLACED = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOFRAME  = 3'd4,
        ST_RESERVED = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_TRANSLATE = 1'b0,
        FUNC_RESERVE   = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        REG_POLICY      = 3'd0,
        REG_PROCESS     = 3'd1,
        REG_PAGE_KB     = 3'd2,
        REG_PAGE_COUNT  = 3'd3,
        REG_FRAME_LIMIT = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic              func;
        logic [VA_W-1:0]   virtual_address;
        logic [FRAME_W-1:0] frame_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        physical_address;
        logic [FRAME_W-1:0] frame_number;
        logic               evicted_valid;
        logic [PAGE_AW-1:0] evicted_page;
        logic [15:0]        hit_count;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [VPN_W-1:0] dividend;
        logic [KB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VPN_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } div_rsp_t;

endpackage

@@ rtl/ptf_if.sv @@
interface ptf_in_if;
    logic              valid;
    logic              ready;
    ptf_pkg::in_word_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ptf_out_if;
    logic               valid;
    logic               ready;
    ptf_pkg::out_word_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ptf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [26:0] data;
    modport source(output valid, output addr, output data, input ready);
    modport sink(input valid, input addr, input data, output ready);
endinterface

@@ rtl/paged_translation_fifo_lru.sv @@
// Demand-paging translator with FIFO or LRU replacement, one word in and one word out
// at a time. On a translate word the page number comes from a serial divider that
// resolves one of 16 quotient bits per cycle, then the page table memory is read. A
// miss adds a scan of the frame bitmap memory, a read and a check of each 64-bit row
// over up to 64 rows, and a read and a write of the evicted frame's row when that
// frame lies in another row. A reserve word reads its bitmap row and writes it back.
// The bitmap needs no clearing pass after reset: each row has a valid flag, and a row
// that was never written reads as all frames free. A new word is taken as soon as the
// previous one has been placed in the output register, even if that result has not
// yet been taken.
`include "paged_translation_fifo_lru_assert.svh"

module paged_translation_fifo_lru (
    input logic       clk,
    input logic       rst_n,
    ptf_in_if.sink    req,
    ptf_out_if.source rsp,
    ptf_cfg_if.sink   cfg
);
    import ptf_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DIV      = 14'b00000000000010,
        S_CHECK    = 14'b00000000000100,
        S_HIT      = 14'b00000000001000,
        S_VICT     = 14'b00000000010000,
        S_SCAN_RD  = 14'b00000000100000,
        S_SCAN_CHK = 14'b00000001000000,
        S_CLR_RD   = 14'b00000010000000,
        S_CLR_WR   = 14'b00000100000000,
        S_COMMIT   = 14'b00001000000000,
        S_RSV_RD   = 14'b00010000000000,
        S_RSV_WR   = 14'b00100000000000,
        S_MUL      = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic        policy_reg;
    logic [26:0] process_reg;
    logic [10:0] kb_reg;
    logic [6:0]  pcount_reg;
    logic [4:0]  flimit_reg;

    // Derived configuration.
    logic [KB_W-1:0]  kb_eff;
    logic [6:0]       pages;
    logic [CNT_W-1:0] limit;
    logic [13:0]      bits_wide;
    logic [12:0]      bits;

    // Control state.
    logic [MAX_PAGES-1:0] pvalid_reg;
    logic [ROWS-1:0]      rvalid_reg;
    logic [PAGE_AW-1:0]   order_reg [MAX_RESIDENT];
    logic [CNT_W-1:0]     count_reg;
    logic [15:0]          hits_reg;
    logic                 rsp_valid_reg;

    // Per-word working registers.
    logic                 func_reg;
    logic [VA_W-1:0]      va_reg;
    logic [FRAME_W-1:0]   fidx_reg;
    logic                 victim_reg;
    logic [FRAME_W-1:0]   vframe_reg;
    logic [ROW_AW-1:0]    row_reg;
    logic [FRAME_W-1:0]   frame_reg;
    status_t              status_reg;
    logic                 ev_valid_reg;
    logic [PAGE_AW-1:0]   ev_page_reg;
    logic [22:0]          prod_reg;
    out_word_t            out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Memory ports.
    logic               bm_we, bm_re;
    logic [ROW_AW-1:0]  bm_waddr, bm_raddr;
    logic [ROW_W-1:0]   bm_wdata, bm_rdata;
    logic               pf_we, pf_re;
    logic [PAGE_AW-1:0] pf_raddr;
    logic [FRAME_W-1:0] pf_rdata;

    logic                 accept;
    logic [PAGE_AW-1:0]   page;
    logic                 out_of_range;
    logic [ROW_W-1:0]     row_word;
    logic [ROW_W-1:0]     scan_word;
    logic [ROW_W-1:0]     limit_mask;
    logic [ROW_W-1:0]     free_bits;
    logic                 free_any;
    logic [ROW_LSB-1:0]   free_pos;
    logic                 scan_more;
    logic                 vframe_other_row;
    logic [MAX_RESIDENT-1:0] touch_after;
    logic [RES_AW-1:0]    cnt_m1;
    logic [19:0]          offset;
    logic                 out_load;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Zero page size counts as one; page count and resident limit are clamped.
    assign kb_eff    = (kb_reg == '0) ? KB_W'(1) : kb_reg;
    assign pages     = (pcount_reg > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : pcount_reg;
    assign limit     = (flimit_reg == '0) ? CNT_W'(1) :
                       (flimit_reg > CNT_W'(MAX_RESIDENT)) ? CNT_W'(MAX_RESIDENT) : flimit_reg;
    assign bits_wide = pages * pages;
    assign bits      = bits_wide[12:0];

    assign div_req.start    = accept && (req.data.func == FUNC_TRANSLATE);
    assign div_req.dividend = req.data.virtual_address[VA_W-1:KB_SHIFT];
    assign div_req.divisor  = kb_eff;

    ptf_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign page         = div_rsp.quotient[PAGE_AW-1:0];
    assign out_of_range = ({1'b0, va_reg} >= process_reg) ||
                          (div_rsp.quotient >= {{(VPN_W-7){1'b0}}, pages});
    assign offset       = {div_rsp.remainder, va_reg[KB_SHIFT-1:0]};
    assign cnt_m1       = RES_AW'(count_reg - 1'b1);

    // Bitmap row as read, with rows that were never written reading as free.
    assign row_word = rvalid_reg[row_reg] ? bm_rdata : '0;

    // During a replacement the victim's frame counts as free while searching.
    always_comb
    begin
        scan_word = row_word;
        if (victim_reg && (vframe_reg[FRAME_W-1:ROW_LSB] == row_reg))
        begin
            scan_word[vframe_reg[ROW_LSB-1:0]] = 1'b0;
        end
    end

    // Only frames below page_count squared are searched.
    always_comb
    begin
        if ({1'b0, row_reg} < bits[12:ROW_LSB])
        begin
            limit_mask = '1;
        end
        else if ({1'b0, row_reg} == bits[12:ROW_LSB])
        begin
            limit_mask = (ROW_W'(1) << bits[ROW_LSB-1:0]) - ROW_W'(1);
        end
        else
        begin
            limit_mask = '0;
        end
    end

    assign free_bits = ~scan_word & limit_mask;

    always_comb
    begin
        free_any = 1'b0;
        free_pos = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                free_any = 1'b1;
                free_pos = ROW_LSB'(j);
            end
        end
    end

    assign scan_more        = {({1'b0, row_reg} + 7'd1), {ROW_LSB{1'b0}}} < bits;
    assign vframe_other_row = victim_reg && (vframe_reg[FRAME_W-1:ROW_LSB] != row_reg);

    // Resident entries from the first match onward, used to move a hit page to the end.
    always_comb
    begin
        touch_after = '0;
        for (int i = 0; i < MAX_RESIDENT; i++)
        begin
            touch_after[i] = ((order_reg[i] == page) && (CNT_W'(i) < count_reg)) ||
                             ((i > 0) ? touch_after[(i > 0) ? i - 1 : 0] : 1'b0);
        end
    end

    // Bitmap memory port selection.
    always_comb
    begin
        bm_re    = 1'b0;
        bm_raddr = row_reg;
        bm_we    = 1'b0;
        bm_waddr = row_reg;
        bm_wdata = scan_word;
        case (state_reg)
            S_SCAN_RD:
            begin
                bm_re = 1'b1;
            end
            S_CLR_RD:
            begin
                bm_re    = 1'b1;
                bm_raddr = vframe_reg[FRAME_W-1:ROW_LSB];
            end
            S_RSV_RD:
            begin
                bm_re    = 1'b1;
                bm_raddr = fidx_reg[FRAME_W-1:ROW_LSB];
            end
            S_SCAN_CHK:
            begin
                bm_we    = free_any;
                bm_wdata = scan_word | (ROW_W'(1) << free_pos);
            end
            S_CLR_WR:
            begin
                bm_we    = 1'b1;
                bm_waddr = vframe_reg[FRAME_W-1:ROW_LSB];
                bm_wdata = (rvalid_reg[vframe_reg[FRAME_W-1:ROW_LSB]] ? bm_rdata : '0) &
                           ~(ROW_W'(1) << vframe_reg[ROW_LSB-1:0]);
            end
            S_RSV_WR:
            begin
                bm_we    = 1'b1;
                bm_waddr = fidx_reg[FRAME_W-1:ROW_LSB];
                bm_wdata = (rvalid_reg[fidx_reg[FRAME_W-1:ROW_LSB]] ? bm_rdata : '0) |
                           (ROW_W'(1) << fidx_reg[ROW_LSB-1:0]);
            end
            default:
            begin
                bm_re = 1'b0;
            end
        endcase
    end

    ptf_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Page table: the frame held by each resident page.
    assign pf_re    = (state_reg == S_CHECK);
    assign pf_raddr = pvalid_reg[page] ? page : order_reg[0];
    assign pf_we    = (state_reg == S_COMMIT);

    ptf_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_PAGES)) u_page_frame (
        .clk   (clk),
        .we    (pf_we),
        .waddr (page),
        .wdata (frame_reg),
        .re    (pf_re),
        .raddr (pf_raddr),
        .rdata (pf_rdata)
    );

    assign out_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.data.func == FUNC_RESERVE) ? S_RSV_RD : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (out_of_range)
                begin
                    state_next = S_DONE;
                end
                else if (pvalid_reg[page])
                begin
                    state_next = S_HIT;
                end
                else if (count_reg < limit)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_VICT;
                end
            end
            S_HIT:      state_next = S_MUL;
            S_VICT:     state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (free_any)
                begin
                    state_next = vframe_other_row ? S_CLR_RD : S_COMMIT;
                end
                else if (scan_more)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CLR_RD:   state_next = S_CLR_WR;
            S_CLR_WR:   state_next = S_COMMIT;
            S_COMMIT:   state_next = S_MUL;
            S_RSV_RD:   state_next = S_RSV_WR;
            S_RSV_WR:   state_next = S_DONE;
            S_MUL:      state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= 1'b0;
            process_reg   <= 27'd65536;
            kb_reg        <= 11'd1;
            pcount_reg    <= 7'd64;
            flimit_reg    <= 5'd4;
            pvalid_reg    <= '0;
            rvalid_reg    <= '0;
            count_reg     <= '0;
            hits_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_POLICY:      policy_reg  <= cfg.data[0];
                    REG_PROCESS:     process_reg <= cfg.data;
                    REG_PAGE_KB:     kb_reg      <= cfg.data[10:0];
                    REG_PAGE_COUNT:  pcount_reg  <= cfg.data[6:0];
                    REG_FRAME_LIMIT: flimit_reg  <= cfg.data[4:0];
                    default:         policy_reg  <= policy_reg;
                endcase
            end

            if (bm_we)
            begin
                rvalid_reg[bm_waddr] <= 1'b1;
            end

            if (state_reg == S_HIT)
            begin
                hits_reg <= hits_reg + 16'd1;
            end

            if (state_reg == S_COMMIT)
            begin
                if (victim_reg)
                begin
                    pvalid_reg[order_reg[0]] <= 1'b0;
                end
                else if (count_reg < CNT_W'(MAX_RESIDENT))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                pvalid_reg[page] <= 1'b1;
            end

            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Resident order and per-word payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= req.data.func;
            va_reg       <= req.data.virtual_address;
            fidx_reg     <= req.data.frame_index;
            frame_reg    <= req.data.frame_index;
            status_reg   <= ST_RESERVED;
            victim_reg   <= 1'b0;
            ev_valid_reg <= 1'b0;
            ev_page_reg  <= '0;
            row_reg      <= '0;
        end

        case (state_reg)
            S_CHECK:
            begin
                if (out_of_range)
                begin
                    status_reg <= ST_RANGE;
                end
                else if (!pvalid_reg[page])
                begin
                    victim_reg <= !(count_reg < limit);
                end
            end
            S_HIT:
            begin
                frame_reg  <= pf_rdata;
                status_reg <= ST_HIT;
                if (policy_reg && touch_after[MAX_RESIDENT-1])
                begin
                    for (int i = 0; i < MAX_RESIDENT - 1; i++)
                    begin
                        if (touch_after[i] && (CNT_W'(i + 1) < count_reg))
                        begin
                            order_reg[i] <= order_reg[i + 1];
                        end
                    end
                    order_reg[cnt_m1] <= page;
                end
            end
            S_VICT:
            begin
                vframe_reg <= pvalid_reg[order_reg[0]] ? pf_rdata : '0;
            end
            S_SCAN_CHK:
            begin
                if (free_any)
                begin
                    frame_reg <= {row_reg, free_pos};
                end
                else if (scan_more)
                begin
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    status_reg <= ST_NOFRAME;
                end
            end
            S_COMMIT:
            begin
                if (victim_reg)
                begin
                    // The oldest entry drops out and the new page lands in the last
                    // occupied slot.
                    for (int i = 0; i < MAX_RESIDENT - 1; i++)
                    begin
                        if (RES_AW'(i) != cnt_m1)
                        begin
                            order_reg[i] <= order_reg[i + 1];
                        end
                    end
                    order_reg[cnt_m1] <= page;
                    status_reg        <= ST_REPLACED;
                    ev_valid_reg      <= 1'b1;
                    ev_page_reg       <= order_reg[0];
                end
                else
                begin
                    if (count_reg < CNT_W'(MAX_RESIDENT))
                    begin
                        order_reg[count_reg[RES_AW-1:0]] <= page;
                    end
                    status_reg <= ST_LOADED;
                end
            end
            S_MUL:
            begin
                prod_reg <= frame_reg * kb_eff;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase

        if (out_load)
        begin
            out_reg.status        <= status_reg;
            out_reg.hit_count     <= hits_reg;
            out_reg.evicted_valid <= ev_valid_reg;
            out_reg.evicted_page  <= ev_page_reg;
            if ((status_reg == ST_RANGE) || (status_reg == ST_NOFRAME))
            begin
                out_reg.frame_number <= '0;
            end
            else
            begin
                out_reg.frame_number <= frame_reg;
            end
            if ((status_reg == ST_HIT) || (status_reg == ST_LOADED) ||
                (status_reg == ST_REPLACED))
            begin
                out_reg.physical_address <= 32'({prod_reg, {KB_SHIFT{1'b0}}}) + 32'(offset);
            end
            else
            begin
                out_reg.physical_address <= '0;
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = out_reg;

    // A reserve word never reaches the divider or the page table.
    `PTF_ASSERT_IMP(a_reserve_path, (state_reg == S_DIV) || (state_reg == S_HIT), !func_reg)
    `PTF_ASSERT_IMP(a_div_ready, state_reg == S_CHECK, div_rsp.done)
    `PTF_ASSERT_NEXT(a_hit_count, state_reg == S_HIT, hits_reg == $past(hits_reg) + 16'd1)
    `PTF_ASSERT_IMP(a_evict_status, rsp.valid,
                    rsp.data.evicted_valid == (rsp.data.status == ST_REPLACED))
    `PTF_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_RESIDENT))

endmodule

@@ rtl/ptf_ram.sv @@
module ptf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ptf_div.sv @@
// Restoring divider: one quotient bit per cycle.
module ptf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ptf_pkg::div_req_t req,
    output ptf_pkg::div_rsp_t rsp
);
    import ptf_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [$clog2(VPN_W)-1:0] step_reg;
    logic [VPN_W-1:0]         num_reg;
    logic [KB_W-1:0]          rem_reg;
    logic [KB_W-1:0]          den_reg;
    logic [KB_W:0]            trial;
    logic                     ge;

    assign trial = {rem_reg, num_reg[VPN_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == ($clog2(VPN_W))'(VPN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[VPN_W-2:0], ge};
            rem_reg <= ge ? KB_W'(trial - {1'b0, den_reg}) : trial[KB_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg[REM_W-1:0];

endmodule

@@ tb/sv/paged_translation_fifo_lru_tb.sv @@
`timescale 1ns / 1ps

module paged_translation_fifo_lru_tb;
    import ptf_pkg::*;

    logic clk;
    logic rst_n;

    ptf_in_if  req();
    ptf_out_if rsp();
    ptf_cfg_if cfg();

    paged_translation_fifo_lru i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    // Half of the 8 ns clock period.
    always #4 clk = ~clk;

    // Settle time after the last expected word. It covers a full bitmap miss that could
    // still be in flight, with margin.
    localparam int SETTLE_CYCLES = 200;

    // Shadow copy of the translator: page table, resident order, bitmap and hit counter.
    logic             pt_valid[MAX_PAGES];
    logic [11:0]      pt_frame[MAX_PAGES];
    logic [5:0]       res_order[MAX_RESIDENT];
    int unsigned      res_count;
    bit               frame_used[BITMAP_BITS];
    logic [15:0]      hit_total;

    // Shadow copy of the configuration registers at their reset values.
    logic             lru_mode;
    logic [26:0]      proc_bytes;
    logic [10:0]      page_kb;
    logic [6:0]       page_cnt;
    logic [4:0]       res_limit;

    out_word_t        expected_words[$];
    int               fail_count;
    bit               no_idle;
    int               rsp_stall;

    // Pages the table actually holds; the register may claim more than it has room for.
    function automatic int unsigned table_pages();
        return (page_cnt > MAX_PAGES) ? MAX_PAGES : page_cnt;
    endfunction

    function automatic int unsigned page_bytes_now();
        return ((page_kb == 0) ? 1 : page_kb) * 1024;
    endfunction

    // First free frame of the searched part of the bitmap, claimed on the way; -1 if none.
    function automatic int claim_frame();
        int unsigned side;
        int unsigned bits;
        side = table_pages();
        bits = side * side;
        if (bits > BITMAP_BITS)
            bits = BITMAP_BITS;
        for (int unsigned i = 0; i < bits; i++)
        begin
            if (!frame_used[i])
            begin
                frame_used[i] = 1'b1;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void append_resident(int unsigned pg);
        if (res_count < MAX_RESIDENT)
        begin
            res_order[res_count] = pg[5:0];
            res_count++;
        end
    endfunction

    function automatic void retire_oldest();
        for (int unsigned i = 1; i < res_count && i < MAX_RESIDENT; i++)
            res_order[i-1] = res_order[i];
        if (res_count > 0)
            res_count--;
    endfunction

    // Under LRU a hit moves the page to the most recent end of the resident list.
    function automatic void promote_page(int unsigned pg);
        int unsigned pos;
        pos = res_count;
        for (int unsigned i = 0; i < res_count && i < MAX_RESIDENT; i++)
        begin
            if (res_order[i] == pg)
            begin
                pos = i;
                break;
            end
        end
        if (pos >= res_count || pos >= MAX_RESIDENT)
            return;
        for (int unsigned i = pos + 1; i < res_count && i < MAX_RESIDENT; i++)
            res_order[i-1] = res_order[i];
        res_order[res_count-1] = pg[5:0];
    endfunction

    // Works out the result word for one request and advances the shadow state.
    function automatic out_word_t translate_word(in_word_t w);
        out_word_t   r;
        int unsigned pbytes;
        int unsigned limit;
        int unsigned pg;
        int unsigned offs;
        int unsigned frame;
        int unsigned victim;
        int unsigned vframe;
        int          got;
        logic [63:0] phys;

        pbytes = page_bytes_now();
        limit  = (res_limit == 0) ? 1 : res_limit;
        if (limit > MAX_RESIDENT)
            limit = MAX_RESIDENT;
        r = '0;
        r.hit_count = hit_total;

        if (w.func == FUNC_RESERVE)
        begin
            frame_used[w.frame_index] = 1'b1;
            r.status       = ST_RESERVED;
            r.frame_number = w.frame_index;
            return r;
        end

        pg   = w.virtual_address / pbytes;
        offs = w.virtual_address % pbytes;
        if (w.virtual_address >= proc_bytes || pg >= table_pages())
        begin
            r.status = ST_RANGE;
            return r;
        end

        if (pt_valid[pg])
        begin
            hit_total = hit_total + 16'd1;
            if (lru_mode)
                promote_page(pg);
            frame = pt_frame[pg];
            r.status = ST_HIT;
        end
        else if (res_count < limit)
        begin
            got = claim_frame();
            if (got < 0)
            begin
                r.status = ST_NOFRAME;
                return r;
            end
            frame = got;
            pt_valid[pg] = 1'b1;
            pt_frame[pg] = frame[11:0];
            append_resident(pg);
            r.status = ST_LOADED;
        end
        else
        begin
            // The victim's frame is released first so the search may hand it straight back.
            victim = res_order[0];
            vframe = pt_valid[victim] ? pt_frame[victim] : 0;
            frame_used[vframe] = 1'b0;
            got = claim_frame();
            if (got < 0)
            begin
                // Nothing free even so: the victim keeps its frame and stays resident.
                frame_used[vframe] = 1'b1;
                r.status = ST_NOFRAME;
                return r;
            end
            pt_valid[victim] = 1'b0;
            retire_oldest();
            frame = got;
            pt_valid[pg] = 1'b1;
            pt_frame[pg] = frame[11:0];
            append_resident(pg);
            r.status        = ST_REPLACED;
            r.evicted_valid = 1'b1;
            r.evicted_page  = victim[5:0];
        end

        phys = 64'(frame) * 64'(pbytes) + 64'(offs);
        r.physical_address = phys[31:0];
        r.frame_number     = frame[11:0];
        r.hit_count        = hit_total;
        return r;
    endfunction

    // Offers one word after a random gap and returns once it has been taken.
    // Valid is left high so back-to-back words need no second assignment in one step.
    task automatic send_word(in_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_words.push_back(translate_word(w));
        req.data  <= w;
        req.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic send_xlate(logic [25:0] va);
        in_word_t w;
        w = '0;
        w.func            = FUNC_TRANSLATE;
        w.virtual_address = va;
        w.frame_index     = 12'($urandom);
        send_word(w);
    endtask

    task automatic send_reserve(logic [11:0] idx);
        in_word_t w;
        w = '0;
        w.func            = FUNC_RESERVE;
        w.frame_index     = idx;
        w.virtual_address = 26'($urandom);
        send_word(w);
    endtask

    // Holds off new words until every expected word is back, then lets the block settle.
    task automatic drain_block();
        req.valid <= 1'b0;
        wait (expected_words.size() == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers in index order while the block is idle.
    task automatic set_config(logic pol, logic [26:0] pbytes, logic [10:0] kb,
                              logic [6:0] cnt, logic [4:0] lim);
        logic [26:0] vals[5];
        vals = '{27'(pol), pbytes, 27'(kb), 27'(cnt), 27'(lim)};
        drain_block();
        for (int i = 0; i < 5; i++)
        begin
            cfg.addr  <= 3'(i);
            cfg.data  <= vals[i];
            cfg.valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        lru_mode   = pol;
        proc_bytes = pbytes;
        page_kb    = kb;
        page_cnt   = cnt;
        res_limit  = lim;
    endtask

    // Mostly well-formed translations within a small working set so that hits, loads and
    // replacements all occur; the rest are wide addresses, raw noise and reservations.
    task automatic send_random_word();
        int unsigned pbytes;
        int unsigned span;
        int unsigned pg;
        int unsigned pick;
        logic [63:0] va;
        pbytes = page_bytes_now();
        pick   = $urandom_range(0, 99);
        if (pick < 10)
            send_reserve(12'($urandom));
        else if (pick < 20)
            send_xlate(26'($urandom));
        else
        begin
            span = table_pages();
            if (pick < 75 && span > res_limit + 3)
                span = res_limit + 3;
            pg = $urandom_range(0, span);
            va = 64'(pg) * 64'(pbytes) + 64'($urandom_range(0, pbytes - 1));
            send_xlate(va[25:0]);
        end
    endtask

    // Checks every result word against the oldest expectation and draws the receiver stall.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: %p", rsp.data);
                fail_count++;
            end
            else
            begin
                out_word_t e;
                out_word_t a;
                e = expected_words.pop_front();
                a = rsp.data;
                if (a.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, a.status);
                    fail_count++;
                end
                if (a.physical_address !== e.physical_address)
                begin
                    $error("physical_address: expected %0h, actual %0h",
                           e.physical_address, a.physical_address);
                    fail_count++;
                end
                if (a.frame_number !== e.frame_number)
                begin
                    $error("frame_number: expected %0d, actual %0d",
                           e.frame_number, a.frame_number);
                    fail_count++;
                end
                if (a.evicted_valid !== e.evicted_valid)
                begin
                    $error("evicted_valid: expected %0d, actual %0d",
                           e.evicted_valid, a.evicted_valid);
                    fail_count++;
                end
                if (a.evicted_page !== e.evicted_page)
                begin
                    $error("evicted_page: expected %0d, actual %0d",
                           e.evicted_page, a.evicted_page);
                    fail_count++;
                end
                if (a.hit_count !== e.hit_count)
                begin
                    $error("hit_count: expected %0d, actual %0d", e.hit_count, a.hit_count);
                    fail_count++;
                end
            end
            rsp_stall = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (rsp_stall > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall--;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Reset configuration: FIFO, 64 KB process, 1 KB pages, 64 pages, four resident.
    // Walks loads, hits, replacements, reservations and two range rejections.
    task automatic test_reset_config();
        send_xlate(26'd0);
        send_xlate(26'd0);
        send_xlate(26'd1023);
        send_xlate(26'd1024);
        send_xlate(26'd2048);
        send_xlate(26'd3072);
        send_xlate(26'd4096);
        send_xlate(26'd5);
        send_reserve(12'd4095);
        send_reserve(12'd0);
        send_reserve(12'd1);
        send_xlate(26'd65535);
        send_xlate(26'd65536);
        send_xlate(26'h3FFFFFF);
        send_xlate(26'd2050);
    endtask

    // LRU with three resident pages: a hit must save its page from the next eviction.
    task automatic test_lru_order();
        set_config(1'b1, 27'd65536, 11'd1, 7'd64, 5'd3);
        send_xlate(26'd10 * 1024);
        send_xlate(26'd11 * 1024);
        send_xlate(26'd12 * 1024);
        send_xlate(26'd10 * 1024 + 7);
        send_xlate(26'd13 * 1024);
        send_xlate(26'd10 * 1024 + 9);
        send_xlate(26'd11 * 1024);
    endtask

    // Register values outside their usual span: zero page size, zero and oversized page
    // counts, zero and oversized resident limits, and a limit lowered below the count.
    task automatic test_register_corners();
        set_config(1'b0, 27'd65536, 11'd0, 7'd64, 5'd0);
        send_xlate(26'd30 * 1024);
        send_xlate(26'd31 * 1024);
        set_config(1'b1, 27'd67108864, 11'd1, 7'd0, 5'd4);
        send_xlate(26'd40 * 1024);
        send_xlate(26'd0);
        set_config(1'b0, 27'd67108864, 11'd1, 7'd127, 5'd31);
        for (int i = 0; i < 18; i++)
            send_xlate(26'(i * 1024 + 100 * 1024));
        send_xlate(26'd63 * 1024 + 1023);
        send_xlate(26'd64 * 1024);
        set_config(1'b1, 27'd67108864, 11'd1, 7'd64, 5'd2);
        send_xlate(26'd50 * 1024);
        send_xlate(26'd51 * 1024);
        send_xlate(26'd52 * 1024);
    endtask

    // Two pages search only four bitmap frames; reservations take two of them before a load
    // and a replacement, then a hit and a range rejection follow.
    task automatic test_frame_exhaustion();
        set_config(1'b0, 27'd2048, 11'd1, 7'd2, 5'd1);
        send_reserve(12'd2);
        send_reserve(12'd3);
        send_xlate(26'd0);
        send_xlate(26'd1024);
        send_reserve(12'd0);
        send_reserve(12'd1);
        send_xlate(26'd1500);
        send_xlate(26'd2048);
    endtask

    // Random phases, each with its own settings; the first two are the extremes and one
    // runs with neither side idling.
    task automatic test_random_mix();
        int unsigned kb;
        int unsigned cnt;
        int unsigned pbytes;
        logic [63:0] span;
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
                set_config(1'b1, 27'd67108864, 11'd1024, 7'd64, 5'd16);
            else if (ph == 1)
                set_config(1'b0, 27'd1, 11'd1, 7'd1, 5'd1);
            else
            begin
                case ($urandom_range(0, 3))
                    0: kb = 1;
                    1: kb = 2;
                    2: kb = 4;
                    default: kb = $urandom_range(1, 1024);
                endcase
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(4, 20);
                span = 64'(cnt) * 64'(kb) * 64'd1024;
                if (span > 64'd67108864)
                    span = 64'd67108864;
                pbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 67108864) : span;
                set_config(1'($urandom), 27'(pbytes), 11'(kb), 7'(cnt),
                           5'($urandom_range(1, 16)));
            end
            no_idle = (ph == 4);
            repeat (210) send_random_word();
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.data   = '0;
        cfg.valid  = 1'b0;
        cfg.addr   = '0;
        cfg.data   = '0;
        rsp.ready  = 1'b0;
        rsp_stall  = 0;
        fail_count = 0;
        no_idle    = 1'b0;
        hit_total  = '0;
        res_count  = 0;
        lru_mode   = 1'b0;
        proc_bytes = 27'd65536;
        page_kb    = 11'd1;
        page_cnt   = 7'd64;
        res_limit  = 5'd4;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            pt_valid[i] = 1'b0;
            pt_frame[i] = '0;
        end
        for (int i = 0; i < MAX_RESIDENT; i++)
            res_order[i] = '0;
        for (int i = 0; i < BITMAP_BITS; i++)
            frame_used[i] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_lru_order();
        test_register_corners();
        test_frame_exhaustion();
        test_random_mix();
        drain_block();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
